@@ src/uta_pkg.sv @@
// Shared types, constants and helpers for the unsigned-to-ASCII formatter.
package uta_pkg;

	localparam int VALUE_W       = 64;
	localparam int FIELD_W       = 6;
	localparam int CNT_W         = 7;
	localparam int DIGIT_SLOTS   = 22;
	localparam int DIGIT_IDX_W   = 5;
	localparam int BCD_DIGITS    = 20;
	localparam int BCD_W         = 4 * BCD_DIGITS;
	localparam int DABBLE_CYCLES = 32;
	localparam int DABBLE_CNT_W  = 5;

	localparam logic [1:0] BASE_OCT = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_A     = 8'h61;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [VALUE_W-1:0] value;
		logic [FIELD_W-1:0] field_width;
		logic [FIELD_W-1:0] precision;
		logic               has_precision;
		logic               zero_pad;
		logic               left_align;
		logic               alternate_form;
	} item_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} text_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_SPLIT,
		ST_LAYOUT,
		ST_SIZE,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic decimal;
		logic octal;
		logic dabble;
		logic split;
	} dig_ctl_t;

	typedef struct packed {
		logic                   dabble_last;
		logic                   split_last;
		logic [DIGIT_IDX_W-1:0] nd;
	} dig_sts_t;

	typedef struct packed {
		logic [CNT_W-1:0]       lead;
		logic [1:0]             plen;
		logic [CNT_W-1:0]       zeros;
		logic [DIGIT_IDX_W-1:0] nd;
		logic [CNT_W-1:0]       trail;
	} lay_t;

	function automatic logic [7:0] digit_ascii(input logic [3:0] d);
		logic [7:0] d8;
		d8 = {4'b0000, d};
		if (d < 4'd10)
			return CH_ZERO + d8;
		else
			return CH_A + d8 - 8'd10;
	endfunction

endpackage

@@ src/unsigned_to_padded_ascii.sv @@
// Top level: printf-style octal, decimal and hex formatter for 64-bit unsigned values.
//
//   channel | valid      | stall      | payload            | beat
//   item    | item_valid | item_stall | item (item_t)      | one conversion request
//   text    | text_valid | text_stall | text (text_t)      | one character, last on the final one
//
// Octal and hex: split into digits (up to 22 and 16), then layout, sizing and the characters.
// Decimal: first the shift-add-3 converter, two bit steps per cycle.
// Characters leave at one per cycle while text_stall is low, at most 64; the character sequencer sets the pace.
// item_stall is high from acceptance until the cycle after the last character is loaded
// into the text register; text stalls stretch the character phase.
// Reset clears the sequencer, counters and valid; the digit buffer is written before it is read.
module unsigned_to_padded_ascii #(
	parameter int MAX_FIELD = 62
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  uta_pkg::item_t  item,
	output logic            text_valid,
	input  logic            text_stall,
	output uta_pkg::text_t  text
);

	localparam int FW = uta_pkg::FIELD_W;
	localparam int CW = uta_pkg::CNT_W;
	localparam logic [FW-1:0] SatLim = FW'(MAX_FIELD);

	uta_pkg::ctl_state_t state_q, state_d;

	logic          oct_q, hex_q, value_nz_q, alt_q, left_q, pad_zero_q;
	logic [FW-1:0] width_q, prec_q;
	logic [CW-1:0] zf_q, core_q;
	logic [1:0]    plen_q;

	logic          accept;
	logic          in_oct, in_dec, in_hex, in_empty;
	logic [CW-1:0] nd_w, prec_w, zf_d, core_d, total, npad, width_w;
	logic [1:0]    plen_d;
	logic          start;
	logic          emit_busy;

	uta_pkg::dig_ctl_t dig_ctl;
	uta_pkg::dig_sts_t dig_sts;
	uta_pkg::lay_t     lay;
	logic [uta_pkg::DIGIT_IDX_W-1:0] rd_idx;
	logic [3:0]                      rd_digit;

	assign item_stall = state_q != uta_pkg::ST_IDLE;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		in_oct = 1'b0;
		in_dec = 1'b0;
		in_hex = 1'b0;
		unique case (item.cmd)
			uta_pkg::BASE_OCT: in_oct = 1'b1;
			uta_pkg::BASE_DEC: in_dec = 1'b1;
			default:           in_hex = 1'b1;
		endcase
	end

	assign in_empty = item.has_precision && (item.precision == '0) && (item.value == '0);

	always_ff @(posedge clk) begin
		if (accept) begin
			oct_q      <= in_oct;
			hex_q      <= in_hex;
			value_nz_q <= item.value != '0;
			alt_q      <= item.alternate_form;
			left_q     <= item.left_align;
			pad_zero_q <= item.zero_pad && !item.has_precision && !item.left_align;
			width_q    <= (item.field_width > SatLim) ? SatLim : item.field_width;
			prec_q     <= (item.precision > SatLim) ? SatLim : item.precision;
		end
		if (state_q == uta_pkg::ST_LAYOUT) begin
			zf_q   <= zf_d;
			core_q <= core_d;
			plen_q <= plen_d;
		end
	end

	// Zero fill and prefix length.
	always_comb begin
		nd_w   = {{(CW-uta_pkg::DIGIT_IDX_W){1'b0}}, dig_sts.nd};
		prec_w = {{(CW-FW){1'b0}}, prec_q};
		zf_d   = (prec_w > nd_w) ? prec_w - nd_w : '0;
		core_d = zf_d + nd_w;
		plen_d = 2'd0;
		if (alt_q) begin
			if (oct_q) begin
				if (core_d == '0 || (zf_d == '0 && value_nz_q))
					plen_d = 2'd1;
			end else if (hex_q && value_nz_q) begin
				plen_d = 2'd2;
			end
		end
	end

	// Padding split.
	always_comb begin
		width_w   = {{(CW-FW){1'b0}}, width_q};
		total     = core_q + {{(CW-2){1'b0}}, plen_q};
		npad      = (width_w > total) ? width_w - total : '0;
		lay.lead  = (!left_q && !pad_zero_q) ? npad : '0;
		lay.plen  = plen_q;
		lay.zeros = (pad_zero_q ? npad : '0) + zf_q;
		lay.nd    = dig_sts.nd;
		lay.trail = left_q ? npad : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= uta_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d         = state_q;
		start           = 1'b0;
		dig_ctl.load    = accept;
		dig_ctl.decimal = in_dec;
		dig_ctl.octal   = oct_q;
		dig_ctl.dabble  = 1'b0;
		dig_ctl.split   = 1'b0;
		unique case (state_q)
			uta_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_empty)
						state_d = uta_pkg::ST_LAYOUT;
					else if (in_dec)
						state_d = uta_pkg::ST_DABBLE;
					else
						state_d = uta_pkg::ST_SPLIT;
				end
			end
			uta_pkg::ST_DABBLE: begin
				dig_ctl.dabble = 1'b1;
				if (dig_sts.dabble_last)
					state_d = uta_pkg::ST_SPLIT;
			end
			uta_pkg::ST_SPLIT: begin
				dig_ctl.split = 1'b1;
				if (dig_sts.split_last)
					state_d = uta_pkg::ST_LAYOUT;
			end
			uta_pkg::ST_LAYOUT: begin
				state_d = uta_pkg::ST_SIZE;
			end
			uta_pkg::ST_SIZE: begin
				start   = 1'b1;
				state_d = uta_pkg::ST_EMIT;
			end
			uta_pkg::ST_EMIT: begin
				if (!emit_busy)
					state_d = uta_pkg::ST_IDLE;
			end
			default: state_d = uta_pkg::ST_IDLE;
		endcase
	end

	uta_digit_unit u_digit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dig_ctl),
		.value    (item.value),
		.rd_idx   (rd_idx),
		.rd_digit (rd_digit),
		.sts      (dig_sts)
	);

	uta_emitter u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.lay        (lay),
		.busy       (emit_busy),
		.rd_idx     (rd_idx),
		.rd_digit   (rd_digit),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

	a_busy_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_busy |-> state_q == uta_pkg::ST_EMIT)
		else $error("sequencer left emit while characters remain");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> dig_sts.nd == '0)
		else $error("digit count not cleared on a new beat");

endmodule

@@ src/uta_digit_unit.sv @@
// Digit extraction: shift-add-3 binary to BCD for decimal, then one digit per cycle into the digit buffer.
module uta_digit_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  uta_pkg::dig_ctl_t                      ctl,
	input  logic [uta_pkg::VALUE_W-1:0]            value,
	input  logic [uta_pkg::DIGIT_IDX_W-1:0]        rd_idx,
	output logic [3:0]                             rd_digit,
	output uta_pkg::dig_sts_t                      sts
);

	logic [uta_pkg::VALUE_W-1:0]      bin_q;
	logic [uta_pkg::BCD_W-1:0]        work_q;
	logic [uta_pkg::DABBLE_CNT_W-1:0] dab_cnt_q;
	logic [uta_pkg::DIGIT_IDX_W-1:0]  nd_q;
	logic [3:0]                       digit_mem [uta_pkg::DIGIT_SLOTS];

	logic [uta_pkg::BCD_W-1:0]   bcd_a;
	logic [uta_pkg::VALUE_W-1:0] bin_a;
	logic [uta_pkg::BCD_W-1:0]   shifted;
	logic [3:0]                  digit_new;

	// Two shift-add-3 steps per cycle.
	always_comb begin
		bcd_a = work_q;
		bin_a = bin_q;
		for (int r = 0; r < 2; r++) begin
			for (int k = 0; k < uta_pkg::BCD_DIGITS; k++) begin
				if (bcd_a[4*k +: 4] >= 4'd5)
					bcd_a[4*k +: 4] = bcd_a[4*k +: 4] + 4'd3;
			end
			{bcd_a, bin_a} = {bcd_a[uta_pkg::BCD_W-2:0], bin_a, 1'b0};
		end
	end

	always_comb begin
		if (ctl.octal) begin
			shifted   = work_q >> 3;
			digit_new = {1'b0, work_q[2:0]};
		end else begin
			shifted   = work_q >> 4;
			digit_new = work_q[3:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q  <= value;
			work_q <= ctl.decimal ? '0 :
				{{(uta_pkg::BCD_W-uta_pkg::VALUE_W){1'b0}}, value};
		end else if (ctl.dabble) begin
			bin_q  <= bin_a;
			work_q <= bcd_a;
		end else if (ctl.split) begin
			work_q <= shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dab_cnt_q <= '0;
			nd_q      <= '0;
		end else if (ctl.load) begin
			dab_cnt_q <= '0;
			nd_q      <= '0;
		end else begin
			if (ctl.dabble)
				dab_cnt_q <= dab_cnt_q + 1'b1;
			if (ctl.split)
				nd_q <= nd_q + 1'b1;
		end
	end

	// Registered read: rd_idx names the digit needed in the next cycle.
	always_ff @(posedge clk) begin
		if (ctl.split)
			digit_mem[nd_q] <= digit_new;
		rd_digit <= digit_mem[rd_idx];
	end

	assign sts.dabble_last = dab_cnt_q == uta_pkg::DABBLE_CNT_W'(uta_pkg::DABBLE_CYCLES - 1);
	assign sts.split_last  = shifted == '0;
	assign sts.nd          = nd_q;

	a_split_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.split |-> nd_q < uta_pkg::DIGIT_IDX_W'(uta_pkg::DIGIT_SLOTS))
		else $error("digit buffer overrun");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dabble |-> !ctl.split && !ctl.load)
		else $error("digit unit given two operations at once");

endmodule

@@ src/uta_emitter.sv @@
// Character sequencer: walks the output positions and drives the registered text beat.
module uta_emitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  uta_pkg::lay_t                   lay,
	output logic                            busy,
	output logic [uta_pkg::DIGIT_IDX_W-1:0] rd_idx,
	input  logic [3:0]                      rd_digit,
	output logic                            text_valid,
	input  logic                            text_stall,
	output uta_pkg::text_t                  text
);

	localparam int CW = uta_pkg::CNT_W;

	logic          active_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] b_lead_q, b_pfx_q, b_zero_q, b_dig_q, b_end_q;
	logic          text_valid_q;
	uta_pkg::text_t text_q;

	logic [CW-1:0] s_pfx, s_zero, s_dig, s_end;
	logic [CW-1:0] pos_n, dig_base;
	logic [CW-1:0] dig_off;
	logic          advance;
	logic          is_last;
	logic [7:0]    ch;

	assign s_pfx  = lay.lead + {{(CW-2){1'b0}}, lay.plen};
	assign s_zero = s_pfx + lay.zeros;
	assign s_dig  = s_zero + {{(CW-uta_pkg::DIGIT_IDX_W){1'b0}}, lay.nd};
	assign s_end  = s_dig + lay.trail;

	assign advance = active_q && (!text_valid_q || !text_stall);
	assign is_last = pos_q == (b_end_q - 1'b1);

	// Address the digit of the position that is current after this edge.
	assign pos_n    = start ? '0 : (advance ? pos_q + 1'b1 : pos_q);
	assign dig_base = start ? s_dig : b_dig_q;
	assign dig_off  = dig_base - 1'b1 - pos_n;
	assign rd_idx   = dig_off[uta_pkg::DIGIT_IDX_W-1:0];

	always_comb begin
		if (pos_q < b_lead_q)
			ch = uta_pkg::CH_SPACE;
		else if (pos_q < b_pfx_q)
			ch = (pos_q == b_lead_q) ? uta_pkg::CH_ZERO : uta_pkg::CH_X;
		else if (pos_q < b_zero_q)
			ch = uta_pkg::CH_ZERO;
		else if (pos_q < b_dig_q)
			ch = uta_pkg::digit_ascii(rd_digit);
		else
			ch = uta_pkg::CH_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			pos_q        <= '0;
			text_valid_q <= 1'b0;
		end else begin
			if (start) begin
				active_q <= s_end != '0;
				pos_q    <= '0;
			end else if (advance) begin
				pos_q <= pos_q + 1'b1;
				if (is_last)
					active_q <= 1'b0;
			end
			if (advance)
				text_valid_q <= 1'b1;
			else if (!text_stall)
				text_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			b_lead_q <= lay.lead;
			b_pfx_q  <= s_pfx;
			b_zero_q <= s_zero;
			b_dig_q  <= s_dig;
			b_end_q  <= s_end;
		end
		if (advance) begin
			text_q.character <= ch;
			text_q.last      <= is_last;
		end
	end

	assign busy       = active_q;
	assign text_valid = text_valid_q;
	assign text       = text_q;

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> pos_q < b_end_q)
		else $error("position past end of text");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !active_q)
		else $error("start while emitting");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && text_stall) |=> (text_valid && $stable(text)))
		else $error("stalled beat changed");

endmodule

@@ sim/tb_top.sv @@
// Testbench for unsigned_to_padded_ascii: directed and random items checked against expected strings or a predictor.
module tb_top;

	localparam int N_DIRECTED   = 25;
	localparam int N_RANDOM     = 200;
	localparam int SAT_FIELD    = 62;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		uta_pkg::item_t it;
		bit             typed;
		string          txt;
	} dir_row_t;

	logic           clk        = 1'b0;
	logic           arst_n     = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	uta_pkg::item_t item       = '0;
	logic           text_valid;
	logic           text_stall = 1'b0;
	uta_pkg::text_t text;

	uta_pkg::text_t pending_chars[$];
	dir_row_t       dir_tab [N_DIRECTED];
	int             err_count  = 0;
	int             stall_left = 0;
	bit             calm       = 1'b0;

	always #2 clk = ~clk;

	unsigned_to_padded_ascii u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic uta_pkg::item_t mk(input logic [1:0] c, input logic [63:0] v, input int w,
			input int p, input bit hp, input bit zp, input bit la, input bit af);
		uta_pkg::item_t r;
		r.cmd            = c;
		r.value          = v;
		r.field_width    = 6'(w);
		r.precision      = 6'(p);
		r.has_precision  = hp;
		r.zero_pad       = zp;
		r.left_align     = la;
		r.alternate_form = af;
		return r;
	endfunction

	// Build the expected characters of one conversion and queue them.
	function automatic void format_chars(input uta_pkg::item_t it);
		logic [3:0]  dg [uta_pkg::DIGIT_SLOTS];
		logic [63:0] v;
		logic [3:0]  d;
		logic [7:0]  pfx [2];
		logic [7:0]  seq [$];
		int          nd, zf, core, plen, npad, fw, pr;
		bit          pad_zero;
		fw = (it.field_width > SAT_FIELD) ? SAT_FIELD : int'(it.field_width);
		pr = (it.precision > SAT_FIELD) ? SAT_FIELD : int'(it.precision);
		nd = 0;
		v  = it.value;
		// explicit zero precision with a zero value gives no digits
		if (!(it.has_precision && pr == 0 && it.value == 64'd0)) begin
			do begin
				if (it.cmd == uta_pkg::BASE_DEC) begin
					d = 4'(v % 64'd10);
					v = v / 64'd10;
				end else if (it.cmd == uta_pkg::BASE_OCT) begin
					d = {1'b0, v[2:0]};
					v = v >> 3;
				end else begin
					d = v[3:0];
					v = v >> 4;
				end
				dg[nd] = d;
				nd++;
			end while (v != 64'd0);
		end
		zf   = (pr > nd) ? pr - nd : 0;
		core = zf + nd;
		plen = 0;
		if (it.alternate_form) begin
			if (it.cmd == uta_pkg::BASE_OCT) begin
				if (core == 0 || (zf == 0 && it.value != 64'd0)) begin
					pfx[0] = uta_pkg::CH_ZERO;
					plen   = 1;
				end
			end else if (it.cmd != uta_pkg::BASE_DEC && it.value != 64'd0) begin
				pfx[0] = uta_pkg::CH_ZERO;
				pfx[1] = uta_pkg::CH_X;
				plen   = 2;
			end
		end
		npad     = (fw > plen + core) ? fw - plen - core : 0;
		pad_zero = it.zero_pad && !it.has_precision && !it.left_align;
		if (!it.left_align && !pad_zero)
			repeat (npad) seq.push_back(uta_pkg::CH_SPACE);
		for (int i = 0; i < plen; i++)
			seq.push_back(pfx[i]);
		// prefix goes ahead of the pad zeros
		if (pad_zero)
			repeat (npad) seq.push_back(uta_pkg::CH_ZERO);
		repeat (zf) seq.push_back(uta_pkg::CH_ZERO);
		for (int i = nd - 1; i >= 0; i--)
			seq.push_back((dg[i] < 4'd10) ? uta_pkg::CH_ZERO + 8'(dg[i])
				: uta_pkg::CH_A + 8'(dg[i]) - 8'd10);
		if (it.left_align)
			repeat (npad) seq.push_back(uta_pkg::CH_SPACE);
		for (int i = 0; i < seq.size(); i++)
			pending_chars.push_back('{character: seq[i], last: (i == seq.size() - 1)});
	endfunction

	// Present one item and hold it until accepted; return at the next falling edge.
	task automatic offer(input uta_pkg::item_t it, input bit typed, input string txt);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		if (typed) begin
			for (int i = 0; i < txt.len(); i++)
				pending_chars.push_back('{character: txt[i], last: (i == txt.len() - 1)});
		end else begin
			format_chars(it);
		end
		@(negedge clk);
	endtask

	// Hold off the sender until every expected character is out.
	task automatic wait_empty();
		item_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 5);
		text_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	always @(posedge clk) begin : mon
		uta_pkg::text_t want;
		if (arst_n && text_valid === 1'b1 && text_stall === 1'b0) begin
			if (pending_chars.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat char=%h last=%b",
					text.character, text.last));
			end else begin
				want = pending_chars.pop_front();
				if (text.character !== want.character)
					flag_mismatch($sformatf("char got %h want %h",
						text.character, want.character));
				if (text.last !== want.last)
					flag_mismatch($sformatf("last got %b want %b (char %h)",
						text.last, want.last, want.character));
			end
		end
	end

	initial begin
		#4000000;
		$display("** unsigned_to_padded_ascii: FAILED **");
		$finish;
	end

	initial begin
		uta_pkg::item_t it;
		dir_tab = '{
			'{mk(uta_pkg::BASE_DEC, 64'd0, 0, 0, 0, 0, 0, 0), 1'b1, "0"},
			'{mk(uta_pkg::BASE_DEC, 64'd0, 0, 0, 1, 0, 0, 0), 1'b1, ""},
			'{mk(uta_pkg::BASE_OCT, 64'd0, 0, 0, 1, 0, 0, 1), 1'b1, "0"},
			'{mk(uta_pkg::BASE_HEX, 64'd0, 0, 0, 0, 0, 0, 1), 1'b1, "0"},
			'{mk(uta_pkg::BASE_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0), 1'b1,
				"ffffffffffffffff"},
			'{mk(uta_pkg::BASE_OCT, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0), 1'b1,
				"1777777777777777777777"},
			'{mk(uta_pkg::BASE_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0), 1'b1,
				"18446744073709551615"},
			'{mk(uta_pkg::BASE_HEX, 64'h1f, 8, 0, 0, 1, 0, 1), 1'b1, "0x00001f"},
			'{mk(uta_pkg::BASE_OCT, 64'd8, 0, 0, 0, 0, 0, 1), 1'b1, "010"},
			'{mk(uta_pkg::BASE_OCT, 64'd8, 0, 3, 1, 0, 0, 1), 1'b1, "010"},
			'{mk(uta_pkg::BASE_DEC, 64'd42, 5, 0, 0, 0, 1, 0), 1'b1, "42   "},
			'{mk(uta_pkg::BASE_DEC, 64'd42, 5, 0, 0, 0, 0, 0), 1'b1, "   42"},
			'{mk(uta_pkg::BASE_DEC, 64'd42, 5, 0, 0, 1, 0, 0), 1'b1, "00042"},
			'{mk(uta_pkg::BASE_DEC, 64'd42, 5, 3, 1, 1, 0, 0), 1'b1, "  042"},
			'{mk(2'd3, 64'd255, 0, 0, 0, 0, 0, 0), 1'b1, "ff"},
			'{mk(uta_pkg::BASE_HEX, 64'hab, 63, 0, 0, 0, 0, 0), 1'b0, ""},
			'{mk(uta_pkg::BASE_DEC, 64'd7, 0, 63, 1, 0, 0, 0), 1'b0, ""},
			'{mk(uta_pkg::BASE_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 63, 0, 0, 1, 0, 1), 1'b0, ""},
			'{mk(uta_pkg::BASE_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 0, 62, 1, 0, 0, 1), 1'b0, ""},
			'{mk(uta_pkg::BASE_HEX, 64'd5, 2, 0, 0, 1, 0, 1), 1'b1, "0x5"},
			'{mk(uta_pkg::BASE_DEC, 64'd5, 4, 0, 0, 1, 1, 0), 1'b1, "5   "},
			'{mk(uta_pkg::BASE_HEX, 64'hdeadbeef, 0, 0, 0, 0, 0, 0), 1'b1, "deadbeef"},
			'{mk(uta_pkg::BASE_DEC, 64'd0, 4, 0, 1, 0, 0, 0), 1'b1, "    "},
			'{mk(uta_pkg::BASE_HEX, 64'd0, 0, 0, 1, 0, 0, 1), 1'b1, ""},
			'{mk(uta_pkg::BASE_OCT, 64'd15, 5, 0, 0, 1, 0, 1), 1'b1, "00017"}
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k < N_DIRECTED; k++)
			offer(dir_tab[k].it, dir_tab[k].typed, dir_tab[k].txt);
		wait_empty();

		for (int k = 0; k < N_RANDOM; k++) begin
			calm = (k % 60 >= 45) || (k >= N_RANDOM - 30);
			if (k == N_RANDOM / 2)
				wait_empty();
			it.cmd = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 4))
				0: it.value = 64'd0;
				1: it.value = 64'($urandom_range(0, 1000));
				2: it.value = {$urandom, $urandom};
				3: it.value = 64'd1 << $urandom_range(0, 63);
				default: it.value = 64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(0, 63);
			endcase
			it.field_width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 12));
			it.precision = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 10));
			it.has_precision  = 1'($urandom_range(0, 1));
			it.zero_pad       = 1'($urandom_range(0, 1));
			it.left_align     = 1'($urandom_range(0, 1));
			it.alternate_form = 1'($urandom_range(0, 1));
			offer(it, 1'b0, "");
		end
		item_valid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("** unsigned_to_padded_ascii: PASSED **");
		else
			$display("** unsigned_to_padded_ascii: FAILED **");
		$finish;
	end

endmodule
